// ----- sv/dwdam_pkg.sv -----
// shared types and codes for the deque with delete-all-matching
package dwdam_pkg;

	localparam int OUT_CNT_W = 6;
	localparam int DATA_W    = 64;

	typedef enum logic [1:0] {
		FN_PUSH_FRONT = 2'd0,
		FN_PUSH_BACK  = 2'd1,
		FN_DELETE_ALL = 2'd2,
		FN_DUMP       = 2'd3
	} func_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DELETE,
		ST_DUMP
	} state_t;

endpackage

// ----- sv/deque_with_delete_all_matching_unit.sv -----
// Insert front/back, delete every matching entry, dump in order; one 64-bit entry RAM.
// An insert, an empty delete and an empty dump give one result in the cycle after acceptance.
// Delete of N entries: one RAM read per entry, busy until the walk ends; the result is registered after it.
// Dump of N entries: one result per entry on consecutive cycles, each from a registered RAM read.
// Throughput is set by the single read port of the entry RAM walking the stored entries.
// Reset clears count and front pointer; RAM contents stay undefined. Results cannot be stalled.
module deque_with_delete_all_matching_unit #(
	parameter int CAPACITY = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          func,
	input  logic [dwdam_pkg::DATA_W-1:0]        value,
	output logic                                done,
	output logic [dwdam_pkg::DATA_W-1:0]        data_out,
	output logic [dwdam_pkg::OUT_CNT_W-1:0]     count,
	output logic [dwdam_pkg::OUT_CNT_W-1:0]     removed,
	output logic [1:0]                          status,
	output logic                                last
);
	import dwdam_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IW:0]   CAP_S  = (IW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [IW-1:0] TOP_IX = IW'(CAPACITY - 1);

	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] front,
			input logic [IW-1:0] pos);
		logic [IW:0] s;
		s = {1'b0, front} + {1'b0, pos};
		if (s >= CAP_S) begin
			s = s - CAP_S;
		end
		return s[IW-1:0];
	endfunction

	function automatic logic [OUT_CNT_W-1:0] to_out(input logic [CW-1:0] v);
		logic [CW+OUT_CNT_W-1:0] t;
		t = {{OUT_CNT_W{1'b0}}, v};
		return t[OUT_CNT_W-1:0];
	endfunction

	logic [DATA_W-1:0] mem [CAPACITY];

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     front_q;
	logic [CW-1:0]     rd_pos_q;
	logic [CW-1:0]     kept_q;
	logic [DATA_W-1:0] key_q;
	logic              vld_s1;
	logic [CW-1:0]     pos_s1;
	logic [DATA_W-1:0] rdata_s1;

	logic              done_q, last_q;
	logic [DATA_W-1:0] data_out_q;
	logic [OUT_CNT_W-1:0] count_q, removed_q;
	logic [1:0]        status_q;

	logic              accept, full, rd_issue, walk_end, mem_we, keep_hit;
	logic [IW-1:0]     raddr, waddr, front_dec;
	logic [DATA_W-1:0] wdata;
	func_t             fn;

	assign fn        = func_t'(func);
	assign full      = (cnt_q >= CAP_C);
	assign front_dec = (front_q == '0) ? TOP_IX : front_q - 1'b1;
	assign keep_hit  = vld_s1 && (rdata_s1 != key_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && cnt_q != '0) begin
					if (fn == FN_DELETE_ALL) begin
						state_d = ST_DELETE;
					end else if (fn == FN_DUMP) begin
						state_d = ST_DUMP;
					end
				end
			end
			ST_DELETE, ST_DUMP: begin
				if (rd_pos_q == cnt_q && !vld_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		busy     = 1'b1;
		accept   = 1'b0;
		rd_issue = 1'b0;
		walk_end = 1'b0;
		mem_we   = 1'b0;
		waddr    = slot_of(front_q, kept_q[IW-1:0]);
		wdata    = rdata_s1;
		raddr    = slot_of(front_q, rd_pos_q[IW-1:0]);
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				accept = start;
				if (start && !full) begin
					case (fn)
						FN_PUSH_FRONT: begin
							mem_we = 1'b1;
							waddr  = front_dec;
							wdata  = value;
						end
						FN_PUSH_BACK: begin
							mem_we = 1'b1;
							waddr  = slot_of(front_q, cnt_q[IW-1:0]);
							wdata  = value;
						end
						default: mem_we = 1'b0;
					endcase
				end
			end
			ST_DELETE: begin
				rd_issue = (rd_pos_q != cnt_q);
				walk_end = (rd_pos_q == cnt_q) && !vld_s1;
				// compaction write never lands on a slot still to be read
				mem_we   = keep_hit;
			end
			ST_DUMP: begin
				rd_issue = (rd_pos_q != cnt_q);
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			front_q  <= '0;
			rd_pos_q <= '0;
			kept_q   <= '0;
			vld_s1   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_issue;
			done_q  <= 1'b0;
			if (rd_issue) begin
				rd_pos_q <= rd_pos_q + 1'b1;
			end
			if (accept) begin
				rd_pos_q <= '0;
				kept_q   <= '0;
				case (fn)
					FN_PUSH_FRONT, FN_PUSH_BACK: begin
						done_q <= 1'b1;
						if (!full) begin
							cnt_q <= cnt_q + 1'b1;
							if (fn == FN_PUSH_FRONT) begin
								front_q <= front_dec;
							end
						end
					end
					default: begin
						done_q <= (cnt_q == '0);
					end
				endcase
			end
			if (state_q == ST_DELETE && keep_hit) begin
				kept_q <= kept_q + 1'b1;
			end
			if (walk_end) begin
				done_q <= 1'b1;
				cnt_q  <= kept_q;
			end
			if (state_q == ST_DUMP && vld_s1) begin
				done_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q      <= value;
			data_out_q <= '0;
			removed_q  <= '0;
			last_q     <= 1'b1;
			status_q   <= STAT_OK;
			count_q    <= to_out(cnt_q);
			case (fn)
				FN_PUSH_FRONT, FN_PUSH_BACK: begin
					if (full) begin
						status_q <= STAT_FULL;
					end else begin
						count_q <= to_out(cnt_q + 1'b1);
					end
				end
				FN_DUMP: begin
					if (cnt_q == '0) begin
						status_q <= STAT_EMPTY;
					end
				end
				default: status_q <= STAT_OK;
			endcase
		end
		pos_s1 <= rd_pos_q;
		if (walk_end) begin
			data_out_q <= '0;
			count_q    <= to_out(kept_q);
			removed_q  <= to_out(cnt_q - kept_q);
			status_q   <= STAT_OK;
			last_q     <= 1'b1;
		end
		if (state_q == ST_DUMP && vld_s1) begin
			data_out_q <= rdata_s1;
			count_q    <= to_out(cnt_q);
			removed_q  <= '0;
			status_q   <= STAT_OK;
			last_q     <= (pos_s1 + 1'b1 == cnt_q);
		end
	end

	assign done     = done_q;
	assign data_out = data_out_q;
	assign count    = count_q;
	assign removed  = removed_q;
	assign status   = status_q;
	assign last     = last_q;

endmodule

// ----- sv/dwdam_checker.sv -----
// port-level checks for the deque with delete-all-matching, bound to the top level
module dwdam_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [1:0]                          func,
	input logic                                done,
	input logic [dwdam_pkg::DATA_W-1:0]        data_out,
	input logic [dwdam_pkg::OUT_CNT_W-1:0]     count,
	input logic [dwdam_pkg::OUT_CNT_W-1:0]     removed,
	input logic [1:0]                          status,
	input logic                                last
);
	import dwdam_pkg::*;

	// an accepted insert transaction answers in the next cycle
	a_insert_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FN_PUSH_FRONT || func == FN_PUSH_BACK))
		|=> (done && last))
		else $error("insert transaction gave no result in the next cycle");

	// dump results come on consecutive cycles until the last one
	a_dump_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |=> done)
		else $error("gap inside a dump burst");

	a_empty_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_EMPTY) |-> (last && count == '0 && data_out == '0))
		else $error("empty dump result malformed");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL) |-> (last && removed == '0 && data_out == '0))
		else $error("full reject result malformed");

endmodule

bind deque_with_delete_all_matching_unit dwdam_checker u_dwdam_checker (.*);
